### hdl/servo_ramp_step_generator_macros.svh
// Assertion macros for the servo ramp step generator.
// Every check is clocked on clk_i and disabled while rst_ni is low.
`ifndef SERVO_RAMP_STEP_GENERATOR_MACROS_SVH
`define SERVO_RAMP_STEP_GENERATOR_MACROS_SVH

`ifndef ASSERT_OFF
`define SRSG_ASSERT_NOW(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);
`define SRSG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define SRSG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SRSG_ASSERT_NOW(lbl, cond, msg)
`define SRSG_ASSERT_IMP(lbl, ante, cons, msg)
`define SRSG_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

### hdl/srsg_pkg.sv
package srsg_pkg;

  localparam int unsigned MaxSteps = 64;
  localparam int unsigned DegW     = 7;
  localparam int unsigned PosW     = 8;
  localparam int unsigned DelayW   = 21;
  localparam int unsigned CfgW     = 10;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned SqW      = 16;
  localparam int unsigned UpcW     = 3;

  localparam logic [PosW-1:0] PosMax    = 8'd180;
  localparam logic [PosW-1:0] PosCenter = 8'd90;
  localparam logic [SqW-1:0]  SqBit0    = 16'h4000;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_MAX_DELAY  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_FOCUS      = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_MULTIPLIER = 2'd2;

  // command and direction codes
  localparam logic CMD_SET  = 1'b0;
  localparam logic CMD_MOVE = 1'b1;
  localparam logic [1:0] DIR_LEFT  = 2'd0;
  localparam logic [1:0] DIR_RIGHT = 2'd1;
  localparam logic [1:0] DIR_UP    = 2'd2;
  localparam logic [1:0] DIR_DOWN  = 2'd3;

  // microprogram addresses
  localparam logic [UpcW-1:0] U_FETCH = 3'd0;
  localparam logic [UpcW-1:0] U_MOVE  = 3'd1;
  localparam logic [UpcW-1:0] U_SQRT  = 3'd2;
  localparam logic [UpcW-1:0] U_DIFF  = 3'd3;
  localparam logic [UpcW-1:0] U_MUL   = 3'd4;
  localparam logic [UpcW-1:0] U_EMIT  = 3'd5;
  localparam logic [UpcW-1:0] U_SET   = 3'd6;

  typedef enum logic [1:0] {
    JC_NEXT  = 2'd0,
    JC_FETCH = 2'd1,
    JC_LOOP  = 2'd2,
    JC_EMIT  = 2'd3
  } jump_e;

  typedef struct packed {
    logic            in_rdy;
    logic            ld_move;
    logic            sqrt_it;
    logic            ld_diff;
    logic            ld_mul;
    logic            ld_set;
    logic            emit;
    jump_e           jc;
    logic [UpcW-1:0] target;
  } ctrl_t;

  localparam ctrl_t CtrlNop = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, JC_FETCH, U_FETCH};

  function automatic ctrl_t ucode(input logic [UpcW-1:0] upc);
    ctrl_t cw;
    cw = CtrlNop;
    case (upc)
      U_FETCH: begin
        cw.in_rdy = 1'b1;
        cw.jc     = JC_FETCH;
        cw.target = U_SET;
      end
      U_MOVE: begin
        cw.ld_move = 1'b1;
        cw.jc      = JC_NEXT;
      end
      U_SQRT: begin
        cw.sqrt_it = 1'b1;
        cw.jc      = JC_LOOP;
        cw.target  = U_SQRT;
      end
      U_DIFF: begin
        cw.ld_diff = 1'b1;
        cw.jc      = JC_NEXT;
      end
      U_MUL: begin
        cw.ld_mul = 1'b1;
        cw.jc     = JC_NEXT;
      end
      U_EMIT: begin
        cw.emit   = 1'b1;
        cw.jc     = JC_EMIT;
        cw.target = U_MOVE;
      end
      U_SET: begin
        cw.ld_set = 1'b1;
        cw.jc     = JC_EMIT;
        cw.target = U_EMIT;
      end
      default: cw = CtrlNop;
    endcase
    return cw;
  endfunction

endpackage

### hdl/servo_ramp_step_generator.sv
// Channel | Handshake                     | Beat contents
// --------+-------------------------------+-------------------------------------------
// in      | in_valid_i / in_ready_o       | cmd_i degrees_i direction_i horiz/vert_target_i
// out     | out_valid_o / out_ready_i     | step_delay_o horiz_pos_o vert_pos_o last_o
// cfg     | cfg_we_i (no wait)            | cfg_idx_i cfg_wdata_i
//
// Set command: the set step follows the input beat, then the output load step loads the output register.
// Move segment: each step runs position, 8 square-root iterations of the root unit,
// difference, multiply and output load, in that order.
// Reset: positions to 90, base delay/focus/gain to 10/2/10; no clearing pass.
// Stalls: the output load step waits until the output register is free; the
// input is taken again while the last beat still sits in the output register.
`include "servo_ramp_step_generator_macros.svh"

module servo_ramp_step_generator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [srsg_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [srsg_pkg::CfgW-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          cmd_i,
  input  logic [srsg_pkg::DegW-1:0]     degrees_i,
  input  logic [1:0]                    direction_i,
  input  logic [srsg_pkg::PosW-1:0]     horiz_target_i,
  input  logic [srsg_pkg::PosW-1:0]     vert_target_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [srsg_pkg::DelayW-1:0]   step_delay_o,
  output logic [srsg_pkg::PosW-1:0]     horiz_pos_o,
  output logic [srsg_pkg::PosW-1:0]     vert_pos_o,
  output logic                          last_o
);
  import srsg_pkg::*;

  ctrl_t cw;

  logic [UpcW-1:0]   upc_q, upc_d;
  logic [9:0]        maxd_q, mult_q;
  logic [7:0]        focus_q;
  logic [PosW-1:0]   horiz_q, horiz_d, vert_q, vert_d;
  logic [DegW-1:0]   n_q, a_q, n_sat, half, xv;
  logic [5:0]        x1;
  logic [1:0]        dir_q;
  logic [SqW-1:0]    rem_q, res_q, bit_q;
  logic [SqW:0]      sq_sum;
  logic              sq_ge;
  logic [9:0]        diff_q;
  logic [DelayW-1:0] delay_q;
  logic              last_q;
  logic              out_valid_q, last_out_q;
  logic [DelayW-1:0] delay_out_q;
  logic [PosW-1:0]   horiz_out_q, vert_out_q;
  logic              in_acc, emit_go;

  assign cw      = ucode(upc_q);
  assign in_acc  = cw.in_rdy && in_valid_i;
  assign emit_go = cw.emit && (!out_valid_q || out_ready_i);

  assign n_sat  = (degrees_i > DegW'(MaxSteps)) ? DegW'(MaxSteps) : degrees_i;
  assign half   = n_q >> 1;
  assign xv     = (a_q < half) ? a_q : (n_q - a_q);
  assign x1     = 6'(xv + 7'd1);
  assign sq_sum = {1'b0, res_q} + {1'b0, bit_q};
  assign sq_ge  = {1'b0, rem_q} >= sq_sum;

  // microsequencer
  always_comb begin
    upc_d = upc_q + 3'd1;
    case (cw.jc)
      JC_FETCH: begin
        if (!in_acc) begin
          upc_d = upc_q;
        end else if (cmd_i == CMD_SET) begin
          upc_d = cw.target;
        end else if (n_sat == '0) begin
          upc_d = upc_q;
        end else begin
          upc_d = U_MOVE;
        end
      end
      JC_LOOP: begin
        upc_d = bit_q[0] ? upc_q + 3'd1 : cw.target;
      end
      JC_EMIT: begin
        if (cw.emit) begin
          if (!emit_go) begin
            upc_d = upc_q;
          end else if (last_q) begin
            upc_d = U_FETCH;
          end else begin
            upc_d = cw.target;
          end
        end else begin
          upc_d = cw.target;
        end
      end
      default: upc_d = upc_q + 3'd1;
    endcase
  end

  // one-unit move with saturation
  always_comb begin
    horiz_d = horiz_q;
    vert_d  = vert_q;
    case (dir_q)
      DIR_LEFT:  if (horiz_q != '0)    horiz_d = horiz_q - 8'd1;
      DIR_RIGHT: if (horiz_q < PosMax) horiz_d = horiz_q + 8'd1;
      DIR_UP:    if (vert_q < PosMax)  vert_d  = vert_q + 8'd1;
      default:   if (vert_q != '0)     vert_d  = vert_q - 8'd1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q       <= U_FETCH;
      maxd_q      <= 10'd10;
      focus_q     <= 8'd2;
      mult_q      <= 10'd10;
      horiz_q     <= PosCenter;
      vert_q      <= PosCenter;
      n_q         <= '0;
      a_q         <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      upc_q <= upc_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MAX_DELAY:  maxd_q  <= cfg_wdata_i;
          CFG_FOCUS:      focus_q <= cfg_wdata_i[7:0];
          CFG_MULTIPLIER: mult_q  <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_acc) begin
        n_q <= n_sat;
        a_q <= '0;
        if (cmd_i == CMD_SET) begin
          horiz_q <= (horiz_target_i > PosMax) ? PosMax : horiz_target_i;
          vert_q  <= (vert_target_i > PosMax) ? PosMax : vert_target_i;
        end
      end
      if (cw.ld_move) begin
        horiz_q <= horiz_d;
        vert_q  <= vert_d;
        last_q  <= (a_q + 7'd1) == n_q;
      end
      if (cw.ld_set) begin
        last_q <= 1'b1;
      end
      if (emit_go) begin
        a_q <= a_q + 7'd1;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath: root unit, difference, multiply, output register
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      dir_q <= direction_i;
    end
    if (cw.ld_move) begin
      rem_q <= {14'(focus_q) * 14'(x1), 2'b00};
      res_q <= '0;
      bit_q <= SqBit0;
    end
    if (cw.sqrt_it) begin
      if (sq_ge) begin
        rem_q <= rem_q - sq_sum[SqW-1:0];
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
    if (cw.ld_diff) begin
      diff_q <= ({6'd0, maxd_q} >= res_q) ? 10'({6'd0, maxd_q} - res_q)
                                          : 10'(res_q - {6'd0, maxd_q});
    end
    if (cw.ld_mul) begin
      delay_q <= {1'b0, 20'(mult_q) * 20'(diff_q)};
    end
    if (cw.ld_set) begin
      delay_q <= '0;
    end
    if (emit_go) begin
      delay_out_q <= delay_q;
      horiz_out_q <= horiz_q;
      vert_out_q  <= vert_q;
      last_out_q  <= last_q;
    end
  end

  assign in_ready_o   = cw.in_rdy;
  assign out_valid_o  = out_valid_q;
  assign step_delay_o = delay_out_q;
  assign horiz_pos_o  = horiz_out_q;
  assign vert_pos_o   = vert_out_q;
  assign last_o       = last_out_q;

  `SRSG_ASSERT_NOW(a_pos_range, horiz_q <= PosMax && vert_q <= PosMax, "position above 180")
  `SRSG_ASSERT_IMP(a_step_in_range, upc_q == U_MOVE, a_q < n_q, "step index past count")
  `SRSG_ASSERT_IMP(a_root_narrow, upc_q == U_DIFF, res_q[SqW-1:8] == '0, "root too wide")
  `SRSG_ASSERT_NXT(a_last_to_fetch, emit_go && last_q, upc_q == U_FETCH,
                   "no return to fetch after last beat")

endmodule

### bench/servo_ramp_step_generator_tb.sv
`timescale 1ns / 100ps

module servo_ramp_step_generator_tb;
  import srsg_pkg::*;

  localparam int unsigned StallLimit = 4000;
  localparam int unsigned HoldCycles = 600;
  localparam int unsigned DrainPause = 60;

  typedef struct packed {
    logic [DelayW-1:0] step_delay;
    logic [PosW-1:0]   horiz_pos;
    logic [PosW-1:0]   vert_pos;
    logic              last;
  } step_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_PERIODIC,
    RX_SPARSE
  } rx_mode_e;

  class step_scoreboard;
    logic [PosW-1:0] horiz;
    logic [PosW-1:0] vert;
    logic [CfgW-1:0] base_delay;
    logic [7:0]      focus;
    logic [CfgW-1:0] gain;
    step_t           expected_q[$];
    int unsigned     errors;
    int unsigned     commands_seen;
    int unsigned     steps_checked;

    function new();
      horiz         = PosCenter;
      vert          = PosCenter;
      base_delay    = 10'd10;
      focus         = 8'd2;
      gain          = 10'd10;
      errors        = 0;
      commands_seen = 0;
      steps_checked = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] val);
      case (idx)
        CFG_MAX_DELAY:  base_delay = val;
        CFG_FOCUS:      focus = val[7:0];
        CFG_MULTIPLIER: gain = val;
        default: ;
      endcase
    endfunction

    function int unsigned int_root(int unsigned v);
      int unsigned r;
      r = 0;
      while ((r + 1) * (r + 1) <= v) r++;
      return r;
    endfunction

    function logic [DelayW-1:0] ramp_delay(int unsigned x1);
      int unsigned root;
      int unsigned diff;
      root = int_root(4 * focus * x1);
      diff = (base_delay >= root) ? base_delay - root : root - base_delay;
      return DelayW'(gain * diff);
    endfunction

    function void note_command(logic c, logic [DegW-1:0] deg, logic [1:0] dir,
                               logic [PosW-1:0] ht, logic [PosW-1:0] vt);
      step_t       s;
      int unsigned n;
      int unsigned half;
      int unsigned x;
      commands_seen++;
      if (c == CMD_SET) begin
        horiz = (ht > PosMax) ? PosMax : ht;
        vert  = (vt > PosMax) ? PosMax : vt;
        s = '{step_delay: '0, horiz_pos: horiz, vert_pos: vert, last: 1'b1};
        expected_q.push_back(s);
        return;
      end
      n = (deg > MaxSteps) ? MaxSteps : deg;
      half = n / 2;
      for (int unsigned a = 0; a < n; a++) begin
        x = (a < half) ? a : n - a;
        case (dir)
          DIR_LEFT:  if (horiz > 0) horiz = horiz - 8'd1;
          DIR_RIGHT: if (horiz < PosMax) horiz = horiz + 8'd1;
          DIR_UP:    if (vert < PosMax) vert = vert + 8'd1;
          default:   if (vert > 0) vert = vert - 8'd1;
        endcase
        s.step_delay = ramp_delay(x + 1);
        s.horiz_pos  = horiz;
        s.vert_pos   = vert;
        s.last       = (a + 1 == n);
        expected_q.push_back(s);
      end
    endfunction

    function void check_step(step_t got);
      step_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected step beat: delay %0d horiz %0d vert %0d last %0b",
               got.step_delay, got.horiz_pos, got.vert_pos, got.last);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      steps_checked++;
      if (got.step_delay !== want.step_delay) begin
        $error("step_delay: expected %0d, actual %0d", want.step_delay, got.step_delay);
        errors++;
      end
      if (got.horiz_pos !== want.horiz_pos) begin
        $error("horiz_pos: expected %0d, actual %0d", want.horiz_pos, got.horiz_pos);
        errors++;
      end
      if (got.vert_pos !== want.vert_pos) begin
        $error("vert_pos: expected %0d, actual %0d", want.vert_pos, got.vert_pos);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0b, actual %0b", want.last, got.last);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgW-1:0]     cfg_wdata;
  logic                in_valid;
  logic                in_ready;
  logic                cmd;
  logic [DegW-1:0]     degrees;
  logic [1:0]          direction;
  logic [PosW-1:0]     horiz_target;
  logic [PosW-1:0]     vert_target;
  logic                out_valid;
  logic                out_ready;
  logic [DelayW-1:0]   step_delay;
  logic [PosW-1:0]     horiz_pos;
  logic [PosW-1:0]     vert_pos;
  logic                last;

  step_scoreboard sb = new();
  int unsigned    burst_left = 0;
  int unsigned    reg_writes = 0;
  int unsigned    idle_cycles = 0;
  bit             pressure_go = 1'b0;

  servo_ramp_step_generator dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .cmd_i          (cmd),
    .degrees_i      (degrees),
    .direction_i    (direction),
    .horiz_target_i (horiz_target),
    .vert_target_i  (vert_target),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .step_delay_o   (step_delay),
    .horiz_pos_o    (horiz_pos),
    .vert_pos_o     (vert_pos),
    .last_o         (last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        sb.note_command(cmd, degrees, direction, horiz_target, vert_target);
      if (out_valid && out_ready)
        sb.check_step({step_delay, horiz_pos, vert_pos, last});
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= StallLimit) begin
      $display("timeout: no beat for %0d cycles", StallLimit);
      $display("servo_ramp_step_generator: mismatch");
      $finish;
    end
  end

  // receiver: stall pattern changes per segment; one long hold-off to back up the input
  initial begin : receiver
    rx_mode_e    mode;
    int unsigned len;
    int unsigned k;
    bit          held;
    held = 1'b0;
    out_ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      if (pressure_go && !held) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end
      mode = rx_mode_e'($urandom_range(0, 3));
      len  = $urandom_range(10, 150);
      k    = $urandom_range(2, 6);
      for (int unsigned c = 0; c < len; c++) begin
        case (mode)
          RX_OPEN:     out_ready <= 1'b1;
          RX_COIN:     out_ready <= 1'($urandom_range(0, 1));
          RX_PERIODIC: out_ready <= (c % k == 0);
          default:     out_ready <= ($urandom_range(0, 3) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  task automatic offer(input logic c, input logic [DegW-1:0] d, input logic [1:0] dr,
                       input logic [PosW-1:0] h, input logic [PosW-1:0] v);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 50) : $urandom_range(1, 6);
    end
    burst_left--;
    in_valid     <= 1'b1;
    cmd          <= c;
    degrees      <= d;
    direction    <= dr;
    horiz_target <= h;
    vert_target  <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DrainPause) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    sb.write_reg(idx, val);
    reg_writes++;
    @(posedge clk);
  endtask

  task automatic load_config(input logic [CfgW-1:0] md, input logic [CfgW-1:0] fo,
                             input logic [CfgW-1:0] mu);
    write_reg(CFG_MAX_DELAY, md);
    write_reg(CFG_FOCUS, fo);
    write_reg(CFG_MULTIPLIER, mu);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [PosW-1:0] random_target();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return PosW'($urandom_range(181, 255));
    if (r < 20) return PosW'($urandom_range(0, 5));
    if (r < 30) return PosW'($urandom_range(175, 180));
    return PosW'($urandom_range(0, 180));
  endfunction

  function automatic logic [DegW-1:0] random_degrees();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 4)  return '0;
    if (r < 70) return DegW'($urandom_range(1, 12));
    if (r < 88) return DegW'($urandom_range(13, 40));
    if (r < 95) return DegW'($urandom_range(41, 64));
    return DegW'($urandom_range(65, 127));
  endfunction

  // counts only commands that produce steps
  task automatic run_random(input int unsigned n);
    int unsigned     done;
    logic            c;
    logic [DegW-1:0] d;
    done = 0;
    while (done < n) begin
      c = ($urandom_range(0, 99) < 18) ? CMD_SET : CMD_MOVE;
      d = (c == CMD_SET) ? DegW'($urandom) : random_degrees();
      offer(c, d, 2'($urandom), random_target(), random_target());
      if (c == CMD_SET || d != 0) done++;
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = CFG_MAX_DELAY;
    cfg_wdata    = '0;
    in_valid     = 1'b0;
    cmd          = CMD_SET;
    degrees      = '0;
    direction    = DIR_LEFT;
    horiz_target = '0;
    vert_target  = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: saturation at both ends, ignored fields, degree limits
    offer(CMD_MOVE, 7'd3,   DIR_RIGHT, 8'd0,   8'd0);
    offer(CMD_SET,  7'd127, DIR_DOWN,  8'd0,   8'd0);
    offer(CMD_MOVE, 7'd5,   DIR_LEFT,  8'd0,   8'd0);
    offer(CMD_MOVE, 7'd4,   DIR_DOWN,  8'd0,   8'd0);
    offer(CMD_SET,  7'd0,   DIR_UP,    8'd255, 8'd255);
    offer(CMD_MOVE, 7'd3,   DIR_RIGHT, 8'd0,   8'd0);
    offer(CMD_MOVE, 7'd2,   DIR_UP,    8'd0,   8'd0);
    offer(CMD_SET,  7'd64,  DIR_LEFT,  8'd181, 8'd179);
    offer(CMD_SET,  7'd1,   DIR_RIGHT, 8'd178, 8'd2);
    offer(CMD_MOVE, 7'd1,   DIR_UP,    8'd255, 8'd255);
    offer(CMD_MOVE, 7'd0,   DIR_LEFT,  8'd90,  8'd90);
    offer(CMD_MOVE, 7'd2,   DIR_DOWN,  8'd0,   8'd0);
    offer(CMD_MOVE, 7'd64,  DIR_RIGHT, 8'd0,   8'd0);
    offer(CMD_MOVE, 7'd65,  DIR_LEFT,  8'd0,   8'd0);
    offer(CMD_MOVE, 7'd127, DIR_UP,    8'd0,   8'd0);
    offer(CMD_MOVE, 7'd63,  DIR_DOWN,  8'd0,   8'd0);
    offer(CMD_SET,  7'd0,   DIR_LEFT,  8'd0,   8'd180);
    offer(CMD_MOVE, 7'd7,   DIR_RIGHT, 8'd0,   8'd0);
    offer(CMD_SET,  7'd0,   DIR_LEFT,  8'd90,  8'd90);
    wait_drained();

    load_config(10'd1023, 10'd255, 10'd1023);
    pressure_go = 1'b1;
    run_random(20);
    wait_drained();
    load_config(10'd0, 10'd0, 10'd0);
    run_random(20);
    wait_drained();
    load_config(10'd0, 10'd255, 10'd1023);
    run_random(20);
    wait_drained();
    load_config(CfgW'($urandom_range(0, 40)), CfgW'($urandom_range(0, 255)),
                CfgW'($urandom_range(0, 1023)));
    run_random(20);
    wait_drained();
    load_config(CfgW'($urandom_range(0, 1023)), CfgW'($urandom_range(0, 255)),
                CfgW'($urandom_range(0, 1023)));
    run_random(20);
    wait_drained();

    $display("run: %0d commands, %0d step beats checked, %0d register writes",
             sb.commands_seen, sb.steps_checked, reg_writes);
    $display("covered set/move, all directions, both position limits, degree clamp, ",
             "six register settings");
    if (sb.errors == 0) begin
      $display("servo_ramp_step_generator: match");
    end else begin
      $display("servo_ramp_step_generator: mismatch");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+hdl
hdl/srsg_pkg.sv
hdl/servo_ramp_step_generator.sv
bench/servo_ramp_step_generator_tb.sv
